FILE: hw/rtl/pbm_pkg.sv
// Shared types, constants and helpers for the pixel blend pipeline.
package pbm_pkg;

  typedef enum logic [2:0] {
    MODE_TRANS     = 3'd0,
    MODE_DARKEN    = 3'd1,
    MODE_LIGHTEN   = 3'd2,
    MODE_ALPHA_ADD = 3'd3,
    MODE_ALPHA_SUB = 3'd4
  } blend_mode_e;

  localparam logic [2:0]  REG_BLEND_MODE = 3'd0;
  localparam logic [10:0] HUE_HALF = 11'd768;
  localparam logic [11:0] HUE_FULL = 12'd1536;
  localparam logic [10:0] HUE_GREEN = 11'd512;
  localparam logic [10:0] HUE_BLUE = 11'd1024;
  localparam logic [15:0] SQ_MAX = 16'd65025;
  localparam logic [7:0]  CH_MAX = 8'd255;
  localparam int          RECIP_SHIFT = 24;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [10:0] h;
    logic [7:0]  s;
    logic [7:0]  v;
  } hsv_t;

  typedef struct packed {
    logic [31:0] src;
    logic [7:0]  t;
    logic [2:0]  mode;
  } side_t;

  // floor(x / 255) for x up to 65025, by reciprocal multiply
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * 33'd32897;
    return p[30:23];
  endfunction

endpackage

FILE: hw/rtl/pbm_hsv_fwd.sv
// RGB to HSV with hue turned by half a circle, two register stages.
module pbm_hsv_fwd (
  input  logic         clk_i,
  input  logic         en_i,
  input  pbm_pkg::rgb_t rgb_i,
  output pbm_pkg::hsv_t hsv_o
);
  import pbm_pkg::*;

  logic [24:0] rtab [256];

  for (genvar d = 0; d < 256; d++) begin : g_rtab
    if (d == 0) begin : g_zero
      assign rtab[d] = '0;
    end else begin : g_val
      localparam logic [24:0] RV = 25'(((1 << RECIP_SHIFT) + d - 1) / d);
      assign rtab[d] = RV;
    end
  end

  // stage 1
  logic [7:0]  hi, lo, a, b, mag;
  logic [10:0] base;
  logic signed [8:0] diff;
  logic [7:0]  hi_q, span_q;
  logic [15:0] snum_q, hnum_q;
  logic        neg_q;
  logic [10:0] base_q;

  always_comb begin
    hi = (rgb_i[0] > rgb_i[1]) ? rgb_i[0] : rgb_i[1];
    hi = (hi > rgb_i[2]) ? hi : rgb_i[2];
    lo = (rgb_i[0] < rgb_i[1]) ? rgb_i[0] : rgb_i[1];
    lo = (lo < rgb_i[2]) ? lo : rgb_i[2];
    if (rgb_i[0] == hi) begin
      a = rgb_i[1]; b = rgb_i[2]; base = '0;
    end else if (rgb_i[1] == hi) begin
      a = rgb_i[2]; b = rgb_i[0]; base = HUE_GREEN;
    end else begin
      a = rgb_i[0]; b = rgb_i[1]; base = HUE_BLUE;
    end
    diff = $signed({1'b0, a}) - $signed({1'b0, b});
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q   <= hi;
      span_q <= hi - lo;
      snum_q <= {8'd0, hi - lo} * 16'(CH_MAX);
      hnum_q <= {8'd0, mag} * 16'(CH_MAX);
      neg_q  <= diff[8];
      base_q <= base;
    end
  end

  // stage 2
  logic [40:0] sp, hp;
  logic [7:0]  s_c, q_c;
  logic signed [12:0] hs;
  logic [11:0] h1, h2;
  hsv_t        hsv_q;

  always_comb begin
    sp  = {25'd0, snum_q} * {16'd0, rtab[hi_q]};
    hp  = {25'd0, hnum_q} * {16'd0, rtab[span_q]};
    s_c = (hi_q == '0) ? '0 : sp[31:24];
    q_c = (span_q == '0) ? '0 : hp[31:24];
    hs  = $signed({2'b0, base_q}) + (neg_q ? -$signed({5'd0, q_c}) : $signed({5'd0, q_c}));
    if (hs < 0) hs = hs + $signed({1'b0, HUE_FULL});
    h1 = (s_c == '0 || span_q == '0) ? '0 : hs[11:0];
    h2 = h1 + {1'b0, HUE_HALF};
    if (h2 >= HUE_FULL) h2 = h2 - HUE_FULL;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hsv_q.h <= h2[10:0];
      hsv_q.s <= s_c;
      hsv_q.v <= hi_q;
    end
  end

  assign hsv_o = hsv_q;
endmodule

FILE: hw/rtl/pbm_hsv_back.sv
// HSV back to RGB, four register stages.
module pbm_hsv_back (
  input  logic          clk_i,
  input  logic          en_i,
  input  pbm_pkg::hsv_t hsv_i,
  output pbm_pkg::rgb_t rgb_o
);
  import pbm_pkg::*;

  // stage 3: products
  logic [15:0] psf_q, psg_q, pvs_q;
  logic [2:0]  sec3_q;
  logic [7:0]  s3_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      psf_q  <= {8'd0, hsv_i.s} * {8'd0, hsv_i.h[7:0]};
      psg_q  <= {8'd0, hsv_i.s} * {8'd0, CH_MAX - hsv_i.h[7:0]};
      pvs_q  <= {8'd0, hsv_i.v} * {8'd0, CH_MAX - hsv_i.s};
      sec3_q <= hsv_i.h[10:8];
      s3_q   <= hsv_i.s;
      v3_q   <= hsv_i.v;
    end
  end

  // stage 4: scale down
  logic [7:0] x4_q, iy4_q, iz4_q, s4_q, v4_q;
  logic [2:0] sec4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x4_q   <= div255(pvs_q);
      iy4_q  <= div255(SQ_MAX - psf_q);
      iz4_q  <= div255(SQ_MAX - psg_q);
      sec4_q <= sec3_q;
      s4_q   <= s3_q;
      v4_q   <= v3_q;
    end
  end

  // stage 5: products
  logic [15:0] py5_q, pz5_q;
  logic [7:0]  x5_q, s5_q, v5_q;
  logic [2:0]  sec5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      py5_q  <= {8'd0, v4_q} * {8'd0, iy4_q};
      pz5_q  <= {8'd0, v4_q} * {8'd0, iz4_q};
      x5_q   <= x4_q;
      s5_q   <= s4_q;
      v5_q   <= v4_q;
      sec5_q <= sec4_q;
    end
  end

  // stage 6: scale down and pick by sector
  logic [7:0] y, z;
  rgb_t       c, rgb_q;

  always_comb begin
    y = div255(py5_q);
    z = div255(pz5_q);
    case (sec5_q)
      3'd1:    c = {x5_q, v5_q, y};
      3'd2:    c = {z, v5_q, x5_q};
      3'd3:    c = {v5_q, y, x5_q};
      3'd4:    c = {v5_q, x5_q, z};
      3'd5:    c = {y, x5_q, v5_q};
      default: c = {x5_q, z, v5_q};
    endcase
    if (s5_q == '0) c = {v5_q, v5_q, v5_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rgb_q <= c;
  end

  assign rgb_o = rgb_q;
endmodule

FILE: hw/rtl/pbm_darken.sv
// Darken tail: scale turned colour and subtract from source, two stages.
module pbm_darken (
  input  logic          clk_i,
  input  logic          en_i,
  input  pbm_pkg::rgb_t c_i,
  input  pbm_pkg::rgb_t src_i,
  input  logic [7:0]    u_i,
  output pbm_pkg::rgb_t rgb_o
);
  import pbm_pkg::*;

  logic [2:0][15:0] p_q;
  rgb_t             src_q, d, rgb_q;
  logic [2:0][8:0]  dif;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) p_q[k] <= {8'd0, c_i[k]} * {8'd0, u_i};
      src_q <= src_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = {1'b0, src_q[k]} - {1'b0, div255(p_q[k])};
      d[k]   = dif[k][8] ? '0 : dif[k][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rgb_q <= d;
  end

  assign rgb_o = rgb_q;
endmodule

FILE: hw/rtl/pbm_lanes.sv
// Mix, lighten and alpha modes, two register stages.
module pbm_lanes (
  input  logic           clk_i,
  input  logic           en_i,
  input  pbm_pkg::side_t side_i,
  input  pbm_pkg::rgb_t  dst_i,
  output logic [31:0]    res_o
);
  import pbm_pkg::*;

  rgb_t             s_in;
  logic [2:0][8:0]  sd;
  logic [2:0][7:0]  mag;

  always_comb begin
    s_in = side_i.src[23:0];
    for (int k = 0; k < 3; k++) begin
      sd[k]  = {1'b0, s_in[k]} - {1'b0, dst_i[k]};
      mag[k] = sd[k][8] ? 8'(-sd[k]) : sd[k][7:0];
    end
  end

  // stage 1
  logic [2:0][15:0] tp_q, lp_q;
  logic [2:0]       neg_q;
  rgb_t             s_q, d_q;
  logic [7:0]       sa_q;
  logic [15:0]      pa_q, ps_q;
  logic [2:0]       mode_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        tp_q[k]  <= {8'd0, side_i.t} * {8'd0, mag[k]};
        lp_q[k]  <= {8'd0, dst_i[k]} * {8'd0, CH_MAX - side_i.t};
        neg_q[k] <= sd[k][8];
      end
      s_q    <= s_in;
      d_q    <= dst_i;
      sa_q   <= side_i.src[31:24];
      pa_q   <= {8'd0, side_i.src[31:24]} * {8'd0, side_i.t};
      ps_q   <= {8'd0, CH_MAX - side_i.src[31:24]} * {8'd0, side_i.t};
      mode_q <= side_i.mode;
    end
  end

  // stage 2
  rgb_t            tr, lt;
  logic [2:0][8:0] ls;
  logic [7:0]      q;
  logic [31:0]     res, res_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q     = div255(tp_q[k]);
      tr[k] = neg_q[k] ? d_q[k] - q : d_q[k] + q;
      ls[k] = {1'b0, s_q[k]} + {1'b0, div255(lp_q[k])};
      lt[k] = ls[k][8] ? CH_MAX : ls[k][7:0];
    end
    case (mode_q)
      MODE_LIGHTEN:   res = {sa_q, lt};
      MODE_ALPHA_ADD: res = {div255(pa_q), s_q};
      MODE_ALPHA_SUB: res = {CH_MAX - div255(ps_q), s_q};
      default:        res = {sa_q, tr};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res;
  end

  assign res_o = res_q;
endmodule

FILE: hw/rtl/pixel_blend_modes_top.sv
// Top level of the RGBA pixel blend pipeline with its mode register.
//
//  channel | handshake                         | payload
//  --------+-----------------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o           | source_color_i, dest_color_i, weight_i
//  out     | blended_color_valid_o / _ready_i  | blended_color_o
//  config  | psel/penable/pwrite, pready       | paddr, pwdata, prdata
//
// One item per cycle while the output keeps up; nine register stages from acceptance to result.
// Darken path sets the depth: hue forward, four stages back, two to finish.
// Reset clears the valid bits and the mode; payload registers keep no reset.
// The whole pipe holds while the last stage waits on the output; bubbles stay put.
module pixel_blend_modes_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] source_color_i,
  input  logic [31:0] dest_color_i,
  input  logic [7:0]  weight_i,
  output logic        blended_color_valid_o,
  input  logic        blended_color_ready_i,
  output logic [31:0] blended_color_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pbm_pkg::*;

  localparam int LAST = 8;

  logic              en;
  logic [LAST:0]     vld_q;
  side_t             side_q [LAST+1];
  rgb_t              dst_q, dark;
  hsv_t              hsv;
  rgb_t              turned;
  logic [31:0]       alt, alt_q [3:LAST];
  logic [2:0]        blend_mode_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_BLEND_MODE) ? {29'd0, blend_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= MODE_TRANS;
    end else if (psel && penable && pwrite && paddr[2] == REG_BLEND_MODE[0]) begin
      blend_mode_q <= pwdata[2:0];
    end
  end

  assign en         = !vld_q[LAST] || blended_color_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{src: source_color_i, t: weight_i, mode: blend_mode_q};
      dst_q     <= dest_color_i[23:0];
      for (int i = 1; i <= LAST; i++) side_q[i] <= side_q[i-1];
      alt_q[3]  <= alt;
      for (int i = 4; i <= LAST; i++) alt_q[i] <= alt_q[i-1];
    end
  end

  pbm_lanes u_lanes (
    .clk_i (clk_i),
    .en_i  (en),
    .side_i(side_q[0]),
    .dst_i (dst_q),
    .res_o (alt)
  );

  pbm_hsv_fwd u_fwd (
    .clk_i(clk_i),
    .en_i (en),
    .rgb_i(dst_q),
    .hsv_o(hsv)
  );

  pbm_hsv_back u_back (
    .clk_i(clk_i),
    .en_i (en),
    .hsv_i(hsv),
    .rgb_o(turned)
  );

  pbm_darken u_dark (
    .clk_i(clk_i),
    .en_i (en),
    .c_i  (turned),
    .src_i(side_q[6].src[23:0]),
    .u_i  (CH_MAX - side_q[6].t),
    .rgb_o(dark)
  );

  assign blended_color_valid_o = vld_q[LAST];
  assign blended_color_o = (side_q[LAST].mode == MODE_DARKEN) ?
                           {side_q[LAST].src[31:24], dark} : alt_q[LAST];
endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the RGBA pixel blend pipeline and its mode register.
`timescale 1ns / 1ps

module testbench;
  import pbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PIPE_DEPTH = 9;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  wt;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] source_color_i = '0;
  logic [31:0] dest_color_i = '0;
  logic [7:0]  weight_i = '0;
  logic        blended_color_valid_o;
  logic        blended_color_ready_i = 1'b0;
  logic [31:0] blended_color_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_blend_modes_top u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pixel_t      pending_pixels[$];
  logic [31:0] expected_colors[$];
  logic [2:0]  mode_shadow = 3'd0;
  logic        in_taken = 1'b0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_cycles = 0;
  int          errors = 0;
  int          quiet_cycles = 0;

  function automatic int div_trunc(input int num);
    return (num < 0) ? -((-num) / 255) : num / 255;
  endfunction

  function automatic logic [31:0] blend_pixel(input pixel_t p, input logic [2:0] mode);
    int sr, sg, sb, sa, dr, dg, db, t, u, hi, lo, span, h, s, v;
    int sector, f, x, y, z, cr, cg, cb, r, g, b, a;
    sr = p.src[7:0]; sg = p.src[15:8]; sb = p.src[23:16]; sa = p.src[31:24];
    dr = p.dst[7:0]; dg = p.dst[15:8]; db = p.dst[23:16];
    t = p.wt; u = 255 - t; a = sa;
    case (mode)
      MODE_DARKEN: begin
        hi = (dr > dg) ? dr : dg; hi = (hi > db) ? hi : db;
        lo = (dr < dg) ? dr : dg; lo = (lo < db) ? lo : db;
        span = hi - lo; v = hi;
        s = (hi != 0) ? (span * 255) / hi : 0;
        h = 0;
        if (s != 0 && span != 0) begin
          if (dr == hi) h = ((dg - db) * 255 < 0) ? -((-(dg - db) * 255) / span)
                                                 : ((dg - db) * 255) / span;
          else if (dg == hi) h = 512 + (((db - dr) < 0) ? -((-(db - dr) * 255) / span)
                                                        : ((db - dr) * 255) / span);
          else h = 1024 + (((dr - dg) < 0) ? -((-(dr - dg) * 255) / span)
                                           : ((dr - dg) * 255) / span);
          if (h < 0) h += 1536;
        end
        h += 768;
        if (h >= 1536) h -= 1536;
        if (s == 0) begin
          cr = v; cg = v; cb = v;
        end else begin
          sector = h / 256; f = h & 255;
          x = (v * (255 - s)) / 255;
          y = (v * ((65025 - s * f) / 255)) / 255;
          z = (v * ((65025 - s * (255 - f)) / 255)) / 255;
          case (sector)
            1: begin cr = y; cg = v; cb = x; end
            2: begin cr = x; cg = v; cb = z; end
            3: begin cr = x; cg = y; cb = v; end
            4: begin cr = z; cg = x; cb = v; end
            5: begin cr = v; cg = x; cb = y; end
            default: begin cr = v; cg = z; cb = x; end
          endcase
        end
        r = sr - (cr * u) / 255; g = sg - (cg * u) / 255; b = sb - (cb * u) / 255;
        if (r < 0) r = 0;
        if (g < 0) g = 0;
        if (b < 0) b = 0;
      end
      MODE_LIGHTEN: begin
        r = sr + (dr * u) / 255; g = sg + (dg * u) / 255; b = sb + (db * u) / 255;
        if (r > 255) r = 255;
        if (g > 255) g = 255;
        if (b > 255) b = 255;
      end
      MODE_ALPHA_ADD: begin
        r = sr; g = sg; b = sb; a = (sa * t) / 255;
      end
      MODE_ALPHA_SUB: begin
        r = sr; g = sg; b = sb; a = 255 - ((255 - sa) * t) / 255;
      end
      default: begin
        r = dr + div_trunc(t * (sr - dr));
        g = dg + div_trunc(t * (sg - dg));
        b = db + div_trunc(t * (sb - db));
      end
    endcase
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          pixel_t p;
          p = pending_pixels.pop_front();
          source_color_i <= p.src;
          dest_color_i <= p.dst;
          weight_i <= p.wt;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        blended_color_ready_i <= 1'b0;
      end else begin
        blended_color_ready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (blended_color_valid_o && blended_color_ready_i) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, blended_color_o);
          errors <= errors + 1;
        end else if (blended_color_o !== expected_colors[0]) begin
          $display("%0t: mismatch, expected %h, actual %h", $time, expected_colors[0],
                   blended_color_o);
          errors <= errors + 1;
          void'(expected_colors.pop_front());
        end else begin
          void'(expected_colors.pop_front());
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_colors.push_back(blend_pixel({source_color_i, dest_color_i, weight_i},
                                              mode_shadow));
      end
      in_taken <= in_valid_i && in_ready_o;
      if ((in_valid_i && in_ready_o) || (blended_color_valid_o && blended_color_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic write_mode(input logic [2:0] mode);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_BLEND_MODE[0:0], 2'b00};
    pwdata <= {29'd0, mode};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mode_shadow = mode;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain_pipe();
    while (pending_pixels.size() > 0 || in_valid_i || expected_colors.size() > 0)
      @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.src = $urandom();
    p.dst = $urandom();
    case ($urandom_range(5))
      0: p.wt = 8'd0;
      1: p.wt = 8'd255;
      default: p.wt = 8'($urandom_range(255));
    endcase
    // grey destinations, with all three channels equal, exercise the zero-saturation case
    if ($urandom_range(7) == 0) p.dst[23:8] = {2{p.dst[7:0]}};
    return p;
  endfunction

  task automatic run_phase(input logic [2:0] mode, input int count);
    write_mode(mode);
    // directed corners
    pending_pixels.push_back({32'h00000000, 32'hFFFFFFFF, 8'd0});
    pending_pixels.push_back({32'hFFFFFFFF, 32'h00000000, 8'd255});
    pending_pixels.push_back({32'h80FF0000, 32'h000000FF, 8'd128});
    pending_pixels.push_back({32'h7F00FF00, 32'h0000FF00, 8'd1});
    pending_pixels.push_back({32'hFF0000FF, 32'h00FF0000, 8'd254});
    pending_pixels.push_back({32'h01808080, 32'h00808080, 8'd77});
    pending_pixels.push_back({32'hFE123456, 32'h00FFFF00, 8'd200});
    for (int i = 0; i < count; i++) pending_pixels.push_back(random_pixel());
    drain_pipe();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 6; sink_idle_pct = 61;
    run_phase(MODE_DARKEN, 60);
    // long hold-off on the output while items keep coming
    hold_cycles = 60;
    run_phase(MODE_TRANS, 50);
    src_idle_pct = 61; sink_idle_pct = 6;
    run_phase(MODE_LIGHTEN, 50);
    run_phase(MODE_ALPHA_ADD, 50);
    src_idle_pct = 0; sink_idle_pct = 0;
    run_phase(MODE_ALPHA_SUB, 50);
    run_phase(3'd7, 30);
    run_phase(MODE_DARKEN, 80);
    run_phase(3'd5, 20);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
